[hdl/fprt_pkg.sv]
// ----------------------------------------------------------------------------
// fprt_pkg
// Shared types, register codes and the digit character function for the
// fixed-point radix-to-text converter.
// ----------------------------------------------------------------------------
package fprt_pkg;

	typedef struct packed {
		logic [31:0] whole_value;
		logic [15:0] frac_value;
	} num_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic       is_last;
	} txt_t;

	typedef struct packed {
		logic [5:0] base;
		logic [7:0] point_char;
	} cfg_t;

	typedef struct packed {
		logic we;
		logic re;
	} ram_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_INT_RD,
		ST_INT_OUT,
		ST_POINT,
		ST_FRAC
	} back_st_t;

	localparam logic REG_RADIX = 1'b0;
	localparam logic REG_POINT = 1'b1;

	localparam logic [5:0] RADIX_MIN   = 6'd2;
	localparam logic [5:0] RADIX_MAX   = 6'd36;
	localparam logic [5:0] RADIX_RESET = 6'd10;
	localparam logic [7:0] POINT_RESET = 8'd46;

	// 0-9 then a-z
	function automatic logic [7:0] digit_char(input logic [5:0] d);
		logic [7:0] c;
		if (d < 6'd10) begin
			c = 8'd48 + {2'b00, d};
		end else begin
			c = 8'd87 + {2'b00, d};
		end
		return c;
	endfunction

endpackage

[hdl/fprt_ram.sv]
// ----------------------------------------------------------------------------
// fprt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fprt_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/fprt_front.sv]
// ----------------------------------------------------------------------------
// fprt_front
// Input stage: takes a number, masks it to the configured format, flags a
// nonzero fraction and hands the descriptor to the queue.
// ----------------------------------------------------------------------------
module fprt_front #(
	parameter int IW = 32,
	parameter int FW = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               num_valid,
	output logic               num_ready,
	input  fprt_pkg::num_t     num_item,
	output logic               desc_valid,
	input  logic               desc_ready,
	output logic [IW+FW:0]     desc_data
);

	logic [IW+31:0] whole_ext;
	logic [FW+15:0] frac_ext;
	logic           v_s1;
	logic [IW-1:0]  whole_s1;
	logic [FW-1:0]  frac_s1;
	logic           fnz_s1;

	assign whole_ext = {{IW{1'b0}}, num_item.whole_value};
	assign frac_ext  = {{FW{1'b0}}, num_item.frac_value};

	assign num_ready  = !v_s1 || desc_ready;
	assign desc_valid = v_s1;
	assign desc_data  = {fnz_s1, frac_s1, whole_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (num_ready) begin
			v_s1 <= num_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (num_valid && num_ready) begin
			whole_s1 <= whole_ext[IW-1:0];
			frac_s1  <= frac_ext[FW-1:0];
			fnz_s1   <= |frac_ext[FW-1:0];
		end
	end

endmodule

[hdl/fprt_queue.sv]
// ----------------------------------------------------------------------------
// fprt_queue
// Two-entry queue between the input stage and the conversion engine.
// ----------------------------------------------------------------------------
module fprt_queue #(
	parameter int WIDTH = 49
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = ent_q[rp_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

endmodule

[hdl/fprt_back.sv]
// ----------------------------------------------------------------------------
// fprt_back
// Conversion engine: integer digits by repeated division (eight quotient
// bits per cycle) into a digit stack, read back most significant first,
// then, for a nonzero fraction, point and digits by repeated multiply.
// ----------------------------------------------------------------------------
module fprt_back #(
	parameter int IW   = 32,
	parameter int FW   = 16,
	parameter int MAXF = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  logic [IW+FW:0]        q_data,
	input  fprt_pkg::cfg_t        cfg,
	output fprt_pkg::ram_ctl_t    ram_ctl,
	output logic [$clog2(IW)-1:0] ram_waddr,
	output logic [$clog2(IW)-1:0] ram_raddr,
	output logic [5:0]            ram_wdata,
	input  logic [5:0]            ram_rdata,
	output logic                  txt_valid,
	input  logic                  txt_ready,
	output fprt_pkg::txt_t        txt_item
);

	localparam int PW    = ((IW + 7) / 8) * 8;
	localparam int NSTEP = PW / 8;
	localparam int CW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
	localparam int AW    = $clog2(IW);
	localparam int NW    = $clog2(IW + 1);
	localparam int KW    = $clog2(MAXF + 1);

	fprt_pkg::back_st_t st_q;
	fprt_pkg::back_st_t st_d;

	logic [PW-1:0]  quo_q;
	logic [5:0]     rem_q;
	logic [CW-1:0]  cyc_q;
	logic [NW-1:0]  ndig_q;
	logic [FW-1:0]  frac_q;
	logic           fnz_q;
	logic [KW-1:0]  kcnt_q;
	fprt_pkg::txt_t out_q;
	logic           ov_q;

	logic [PW-1:0]  div_quo;
	logic [5:0]     div_rem;
	logic           last_cyc;
	logic           quo_zero;
	logic [FW+5:0]  prod;
	logic [5:0]     fdig;
	logic [FW-1:0]  nfrac;
	logic           frac_last;
	logic           load_ok;
	logic           load;
	fprt_pkg::txt_t load_item;
	logic [NW-1:0]  ndig_dec;

	// eight restoring steps
	always_comb begin
		logic [6:0]    r7;
		logic [5:0]    r;
		logic [PW-1:0] q;
		r  = rem_q;
		q  = quo_q;
		r7 = '0;
		for (int j = 0; j < 8; j++) begin
			r7 = {r, q[PW-1]};
			q  = {q[PW-2:0], 1'b0};
			if (r7 >= {1'b0, cfg.base}) begin
				r7   = r7 - {1'b0, cfg.base};
				q[0] = 1'b1;
			end
			r = r7[5:0];
		end
		div_quo = q;
		div_rem = r;
	end

	assign last_cyc = cyc_q == CW'(NSTEP - 1);
	assign quo_zero = div_quo == '0;
	assign ndig_dec = ndig_q - NW'(1);

	always_comb begin
		prod  = (FW + 6)'(frac_q) * (FW + 6)'(cfg.base);
		fdig  = prod[FW+5:FW];
		if (fdig >= cfg.base) begin
			fdig = cfg.base - 6'd1;
		end
		nfrac = prod[FW-1:0];
	end

	assign frac_last = (nfrac == '0) || (kcnt_q == KW'(MAXF - 1));
	assign load_ok   = !ov_q || txt_ready;

	assign ram_waddr = ndig_q[AW-1:0];
	assign ram_raddr = ndig_dec[AW-1:0];
	assign ram_wdata = div_rem;
	assign txt_valid = ov_q;
	assign txt_item  = out_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			fprt_pkg::ST_IDLE: begin
				if (q_valid) begin
					st_d = fprt_pkg::ST_DIV;
				end
			end
			fprt_pkg::ST_DIV: begin
				if (last_cyc && quo_zero) begin
					st_d = fprt_pkg::ST_INT_RD;
				end
			end
			fprt_pkg::ST_INT_RD: begin
				st_d = fprt_pkg::ST_INT_OUT;
			end
			fprt_pkg::ST_INT_OUT: begin
				if (load_ok) begin
					if (ndig_q != NW'(1)) begin
						st_d = fprt_pkg::ST_INT_RD;
					end else if (fnz_q) begin
						st_d = fprt_pkg::ST_POINT;
					end else begin
						st_d = fprt_pkg::ST_IDLE;
					end
				end
			end
			fprt_pkg::ST_POINT: begin
				if (load_ok) begin
					st_d = fprt_pkg::ST_FRAC;
				end
			end
			fprt_pkg::ST_FRAC: begin
				if (load_ok && frac_last) begin
					st_d = fprt_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = fprt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		q_ready   = 1'b0;
		ram_ctl   = '0;
		load      = 1'b0;
		load_item = '0;
		case (st_q)
			fprt_pkg::ST_IDLE: begin
				q_ready = 1'b1;
			end
			fprt_pkg::ST_DIV: begin
				ram_ctl.we = last_cyc;
			end
			fprt_pkg::ST_INT_RD: begin
				ram_ctl.re = 1'b1;
			end
			fprt_pkg::ST_INT_OUT: begin
				load              = load_ok;
				load_item.text_char = fprt_pkg::digit_char(ram_rdata);
				load_item.is_last = (ndig_q == NW'(1)) && !fnz_q;
			end
			fprt_pkg::ST_POINT: begin
				load                = load_ok;
				load_item.text_char = cfg.point_char;
				load_item.is_last   = 1'b0;
			end
			fprt_pkg::ST_FRAC: begin
				load                = load_ok;
				load_item.text_char = fprt_pkg::digit_char(fdig);
				load_item.is_last   = frac_last;
			end
			default: begin
				q_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fprt_pkg::ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (txt_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= load_item;
		end
		case (st_q)
			fprt_pkg::ST_IDLE: begin
				quo_q  <= PW'(q_data[IW-1:0]);
				frac_q <= q_data[IW+FW-1:IW];
				fnz_q  <= q_data[IW+FW];
				rem_q  <= '0;
				cyc_q  <= '0;
				ndig_q <= '0;
				kcnt_q <= '0;
			end
			fprt_pkg::ST_DIV: begin
				quo_q <= div_quo;
				if (last_cyc) begin
					rem_q  <= '0;
					cyc_q  <= '0;
					ndig_q <= ndig_q + NW'(1);
				end else begin
					rem_q <= div_rem;
					cyc_q <= cyc_q + CW'(1);
				end
			end
			fprt_pkg::ST_INT_OUT: begin
				if (load_ok) begin
					ndig_q <= ndig_dec;
				end
			end
			fprt_pkg::ST_FRAC: begin
				if (load_ok) begin
					frac_q <= nfrac;
					kcnt_q <= kcnt_q + KW'(1);
				end
			end
			default: begin
				cyc_q <= cyc_q;
			end
		endcase
	end

endmodule

[hdl/fixed_point_radix_to_text.sv]
// ----------------------------------------------------------------------------
// fixed_point_radix_to_text
// Converts an unsigned INT_BITS.FRAC_BITS fixed-point number to its text in
// a configured base (2..36), one ASCII character per output item.
//
// Channels: num_* takes one number per item (valid/ready); txt_* returns
// its characters in order, is_last set on the final one. The APB port holds
// radix (address 0, clamped to 2..36) and point_char (address 4); write them
// only while the block is idle.
// Conversion: each number passes the input stage and the queue; then each
// integer digit takes one full division (eight quotient bits a cycle) into
// the digit stack, each integer character is read back from the stack (a
// read state, then an output state), and the point and the fraction digits
// follow, one multiply per fraction digit. Numbers are converted one at a
// time. A new number is taken while the engine works on the previous one,
// up to three waiting in the input stage and queue. The result register
// holds a character while txt_ready is low and the engine waits. Reset
// empties all stages and sets radix 10 and point '.'.
// ----------------------------------------------------------------------------
module fixed_point_radix_to_text #(
	parameter int INT_BITS        = 32,
	parameter int FRAC_BITS       = 16,
	parameter int MAX_FRAC_DIGITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           num_valid,
	output logic           num_ready,
	input  fprt_pkg::num_t num_item,
	output logic           txt_valid,
	input  logic           txt_ready,
	output fprt_pkg::txt_t txt_item,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	localparam int DW = INT_BITS + FRAC_BITS + 1;
	localparam int AW = $clog2(INT_BITS);

	logic [5:0]            radix_q;
	logic [7:0]            point_q;
	logic [5:0]            eff_base;
	fprt_pkg::cfg_t        cfg;
	logic                  cfg_wr;

	logic                  desc_valid;
	logic                  desc_ready;
	logic [DW-1:0]         desc_data;
	logic                  q_valid;
	logic                  q_ready;
	logic [DW-1:0]         q_data;

	fprt_pkg::ram_ctl_t    ram_ctl;
	logic [AW-1:0]         ram_waddr;
	logic [AW-1:0]         ram_raddr;
	logic [5:0]            ram_wdata;
	logic [5:0]            ram_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == fprt_pkg::REG_POINT) ? {24'd0, point_q} : {26'd0, radix_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= fprt_pkg::RADIX_RESET;
			point_q <= fprt_pkg::POINT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == fprt_pkg::REG_RADIX) begin
				radix_q <= pwdata[5:0];
			end else begin
				point_q <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		eff_base = radix_q;
		if (radix_q < fprt_pkg::RADIX_MIN) begin
			eff_base = fprt_pkg::RADIX_MIN;
		end else if (radix_q > fprt_pkg::RADIX_MAX) begin
			eff_base = fprt_pkg::RADIX_MAX;
		end
	end

	assign cfg.base       = eff_base;
	assign cfg.point_char = point_q;

	fprt_front #(
		.IW(INT_BITS),
		.FW(FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_valid  (num_valid),
		.num_ready  (num_ready),
		.num_item   (num_item),
		.desc_valid (desc_valid),
		.desc_ready (desc_ready),
		.desc_data  (desc_data)
	);

	fprt_queue #(
		.WIDTH(DW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (desc_valid),
		.push_ready (desc_ready),
		.push_data  (desc_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	fprt_back #(
		.IW   (INT_BITS),
		.FW   (FRAC_BITS),
		.MAXF (MAX_FRAC_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.cfg       (cfg),
		.ram_ctl   (ram_ctl),
		.ram_waddr (ram_waddr),
		.ram_raddr (ram_raddr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata),
		.txt_valid (txt_valid),
		.txt_ready (txt_ready),
		.txt_item  (txt_item)
	);

	fprt_ram #(
		.WIDTH(6),
		.DEPTH(INT_BITS)
	) u_stack (
		.clk   (clk),
		.we    (ram_ctl.we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_ctl.re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// stored digits are remainders, always below the base
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_ctl.we |-> (ram_wdata < eff_base))
		else $error("digit stack written with digit not below base");

	// stack is filled and drained in separate phases
	assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_ctl.we && ram_ctl.re))
		else $error("digit stack read and written in the same cycle");

	// every stack read is followed by its output cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_ctl.re |=> !ram_ctl.re && !ram_ctl.we)
		else $error("digit stack read not followed by output cycle");

	// a new number is never taken while the engine is writing or reading
	// the digit stack for an unfinished number
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |-> !ram_ctl.we && !ram_ctl.re)
		else $error("queue popped while engine busy");

endmodule

[bench/tb_fixed_point_radix_to_text.sv]
// ----------------------------------------------------------------------------
// tb_fixed_point_radix_to_text
// Self-checking bench for the fixed-point radix-to-text converter. Numbers
// are sent on the num channel. Every accepted number is expanded into its
// expected characters, using the bench's own copy of the format registers.
// Each character returned on the txt channel is compared in order against
// that list. Directed numbers cover the extremes and the radix clamps. They
// are followed by random numbers under several radix settings and several
// idle and stall patterns, and by a long receiver hold-off that fills the
// block.
// ----------------------------------------------------------------------------
module tb_fixed_point_radix_to_text;

	localparam int FRAC_DIGIT_LIMIT = 16;
	localparam int FRAC_WIDTH       = 16;
	localparam int IDLE_LIMIT       = 4000;
	localparam int HOLD_CYCLES      = 400;
	localparam int SETTLE_CYCLES    = 32;
	localparam int END_CYCLES       = 256;

	localparam logic [2:0] ADDR_RADIX = {fprt_pkg::REG_RADIX, 2'b00};
	localparam logic [2:0] ADDR_POINT = {fprt_pkg::REG_POINT, 2'b00};

	logic           clk;
	logic           arst_n;
	logic           num_valid;
	logic           num_ready;
	fprt_pkg::num_t num_item;
	logic           txt_valid;
	logic           txt_ready;
	fprt_pkg::txt_t txt_item;
	logic           psel;
	logic           penable;
	logic           pwrite;
	logic [2:0]     paddr;
	logic [31:0]    pwdata;
	logic [31:0]    prdata;
	logic           pready;

	logic [5:0]     radix_cfg;
	logic [7:0]     point_cfg;
	fprt_pkg::txt_t pending_text[$];
	fprt_pkg::txt_t want_char;
	int             text_errors;
	int             quiet_cycles;
	int             send_idle_pct;
	int             recv_stall_pct;
	int             hold_left;
	bit             hold_req;

	fixed_point_radix_to_text dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_valid(num_valid),
		.num_ready(num_ready),
		.num_item (num_item),
		.txt_valid(txt_valid),
		.txt_ready(txt_ready),
		.txt_item (txt_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] digit_ascii(input int unsigned d);
		logic [7:0] c;
		if (d < 10) begin
			c = 8'h30 + d[7:0];
		end else begin
			c = 8'h61 + d[7:0] - 8'd10;
		end
		return c;
	endfunction

	function automatic void predict_text(input fprt_pkg::num_t n);
		int unsigned    base;
		int unsigned    whole;
		int unsigned    frac;
		int unsigned    prod;
		logic [7:0]     rev[$];
		fprt_pkg::txt_t chars[$];
		fprt_pkg::txt_t c;
		base = 32'(radix_cfg);
		if (base < 32'(fprt_pkg::RADIX_MIN)) base = 32'(fprt_pkg::RADIX_MIN);
		if (base > 32'(fprt_pkg::RADIX_MAX)) base = 32'(fprt_pkg::RADIX_MAX);
		whole = n.whole_value;
		frac = 32'(n.frac_value);
		c.is_last = 1'b0;
		do begin
			rev.push_front(digit_ascii(whole % base));
			whole = whole / base;
		end while (whole != 0);
		foreach (rev[i]) begin
			c.text_char = rev[i];
			chars.push_back(c);
		end
		if (frac != 0) begin
			c.text_char = point_cfg;
			chars.push_back(c);
			for (int k = 0; k < FRAC_DIGIT_LIMIT && frac != 0; k++) begin
				prod = frac * base;
				c.text_char = digit_ascii(prod >> FRAC_WIDTH);
				chars.push_back(c);
				frac = prod & ((1 << FRAC_WIDTH) - 1);
			end
		end
		chars[chars.size() - 1].is_last = 1'b1;
		foreach (chars[i]) pending_text.push_back(chars[i]);
	endfunction

	// predict on input, check on output, and watch for a stuck run
	always @(posedge clk) begin
		if (num_valid && num_ready) predict_text(num_item);
		if (txt_valid && txt_ready) begin
			if (pending_text.size() == 0) begin
				$error("unexpected item: text_char %02h is_last %0b",
					txt_item.text_char, txt_item.is_last);
				text_errors++;
			end else begin
				want_char = pending_text.pop_front();
				if (txt_item.text_char !== want_char.text_char) begin
					$error("text_char: expected %02h, got %02h",
						want_char.text_char, txt_item.text_char);
					text_errors++;
				end
				if (txt_item.is_last !== want_char.is_last) begin
					$error("is_last: expected %0b, got %0b",
						want_char.is_last, txt_item.is_last);
					text_errors++;
				end
			end
		end
		if ((num_valid && num_ready) || (txt_valid && txt_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb_fixed_point_radix_to_text: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			txt_ready <= 1'b0;
			hold_left--;
		end else begin
			txt_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_num(input logic [31:0] whole, input logic [15:0] frac);
		int gap;
		fprt_pkg::num_t n;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			num_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		n.whole_value = whole;
		n.frac_value = frac;
		num_valid <= 1'b1;
		num_item <= n;
		do @(posedge clk); while (!num_ready);
	endtask

	task automatic wait_text_drained(input int settle);
		num_valid <= 1'b0;
		@(posedge clk);
		while (pending_text.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_RADIX) begin
			radix_cfg = data[5:0];
		end else begin
			point_cfg = data[7:0];
		end
		@(posedge clk);
	endtask

	task automatic set_format(input logic [31:0] radix_word, input logic [31:0] point_word);
		apb_write(ADDR_RADIX, radix_word);
		apb_write(ADDR_POINT, point_word);
	endtask

	task automatic send_random_num();
		logic [31:0] whole;
		logic [15:0] frac;
		case ($urandom_range(3))
			0: whole = $urandom();
			1: whole = $urandom_range(1000);
			2: whole = $urandom() >> $urandom_range(31);
			default: whole = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
		case ($urandom_range(3))
			0: frac = 16'h0;
			1: frac = 16'($urandom());
			2: frac = 16'($urandom()) & (16'hFFFF << $urandom_range(15));
			default: frac = $urandom_range(1) ? 16'hFFFF : 16'h0001;
		endcase
		send_num(whole, frac);
	endtask

	// decimal with '.', straight out of reset
	task automatic test_reset_format();
		send_num(32'd0, 16'h0000);
		send_num(32'hFFFF_FFFF, 16'hFFFF);
		send_num(32'd0, 16'h0001);
		send_num(32'd1, 16'h8000);
		send_num(32'd12345, 16'h0000);
		send_num(32'd0, 16'hFFFF);
		send_num(32'hFFFF_FFFF, 16'h0000);
		send_num(32'd1000000000, 16'h0000);
		send_num(32'd999999999, 16'h4000);
		send_num(32'd9, 16'h0000);
		send_num(32'd10, 16'h0000);
		wait_text_drained(SETTLE_CYCLES);
	endtask

	task automatic test_format_extremes();
		set_format(32'd2, 32'h3A);
		send_num(32'hFFFF_FFFF, 16'hFFFF);
		send_num(32'd0, 16'h0000);
		send_num(32'h8000_0000, 16'h0001);
		send_num(32'd1, 16'h0000);
		wait_text_drained(SETTLE_CYCLES);
		set_format(32'd36, 32'hFF);
		send_num(32'hFFFF_FFFF, 16'hFFFF);
		send_num(32'd35, 16'h0000);
		send_num(32'd36, 16'h8000);
		wait_text_drained(SETTLE_CYCLES);
		// radix 0 and 1 clamp up to base 2
		set_format(32'd0, 32'h00);
		send_num(32'd5, 16'h4000);
		wait_text_drained(SETTLE_CYCLES);
		set_format(32'd1, 32'h00);
		send_num(32'd3, 16'hC000);
		wait_text_drained(SETTLE_CYCLES);
		// radix above 36 clamps down to 36, upper data bits dropped
		set_format(32'd37, 32'h2C);
		send_num(32'd36, 16'h1234);
		wait_text_drained(SETTLE_CYCLES);
		set_format(32'hFFFF_FFFF, 32'hFFFF_FF2C);
		send_num(32'hFFFF_FFFF, 16'hFFFF);
		send_num(32'd1295, 16'hAAAA);
		wait_text_drained(SETTLE_CYCLES);
		set_format(32'd16, 32'h2E);
		send_num(32'hDEAD_BEEF, 16'hBEEF);
		wait_text_drained(SETTLE_CYCLES);
	endtask

	task automatic test_random_phases();
		int          send_pcts[4];
		int          recv_pcts[4];
		logic [5:0]  radix_picks[6];
		logic [31:0] radix_word;
		send_pcts = '{0, 85, 0, 21};
		recv_pcts = '{0, 0, 85, 21};
		radix_picks = '{6'd2, 6'd36, 6'd10, 6'd16, 6'd0, 6'd63};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			for (int s = 0; s < 2; s++) begin
				radix_word = $urandom();
				if (2 * p + s < 6) begin
					radix_word[5:0] = radix_picks[2 * p + s];
				end
				set_format(radix_word, $urandom());
				repeat (30) send_random_num();
				wait_text_drained(SETTLE_CYCLES);
			end
		end
	endtask

	task automatic test_input_stall();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_format(32'd10, 32'h2E);
		hold_req = 1'b1;
		repeat (20) send_random_num();
		wait_text_drained(END_CYCLES);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		num_valid = 1'b0;
		num_item = '0;
		txt_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		radix_cfg = fprt_pkg::RADIX_RESET;
		point_cfg = fprt_pkg::POINT_RESET;
		text_errors = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		hold_req = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_format();
		test_format_extremes();
		test_random_phases();
		test_input_stall();
		if (text_errors == 0) begin
			$display("tb_fixed_point_radix_to_text: PASS");
		end else begin
			$display("tb_fixed_point_radix_to_text: FAIL");
		end
		$finish;
	end

endmodule
